// ===== rtl/core/bfsj_pkg.sv =====
// Shared types and constants of the breaker failure start judge.
package bfsj_pkg;

  localparam int CW     = 24;  // width of one phasor component
  localparam int TW     = 32;  // time tick width
  localparam int LVL_W  = 23;  // threshold register width
  localparam int HOLD_W = 8;
  localparam int XW     = 45;  // raw component width before rounding
  localparam int RW     = 26;  // clamped component width
  localparam int RAD_W  = 50;  // sum of squares width
  localparam int MAG_W  = 25;  // magnitude width
  localparam int IN_W   = 392;
  localparam int OUT_W  = 8;
  localparam int SEL_W  = 3;
  localparam int N_MAG  = 7;

  localparam logic signed [17:0] SQRT3_Q16 = 18'sd113512;
  localparam logic signed [XW-1:0] MAG_CAP = XW'(64'sd16777216);

  // Magnitude slots, in the order they are computed.
  localparam logic [SEL_W-1:0] SEL_A   = 3'd0;
  localparam logic [SEL_W-1:0] SEL_B   = 3'd1;
  localparam logic [SEL_W-1:0] SEL_C   = 3'd2;
  localparam logic [SEL_W-1:0] SEL_I0  = 3'd3;
  localparam logic [SEL_W-1:0] SEL_I2  = 3'd4;
  localparam logic [SEL_W-1:0] SEL_MI0 = 3'd5;
  localparam logic [SEL_W-1:0] SEL_MI2 = 3'd6;

  // Configuration register indexes.
  localparam logic [2:0] REG_PHASE_OVER = 3'd0;
  localparam logic [2:0] REG_ZERO_CHG   = 3'd1;
  localparam logic [2:0] REG_MEM_LOW    = 3'd2;
  localparam logic [2:0] REG_SEQ_PICKUP = 3'd3;
  localparam logic [2:0] REG_INST_SUM   = 3'd4;
  localparam logic [2:0] REG_HOLD_TICKS = 3'd5;

  // Result word with only start_res and in_zero_hold set.
  localparam logic [OUT_W-1:0] HOLD_WORD = 8'h03;

  typedef struct packed {
    logic             load;
    logic             comp;
    logic             rnd;
    logic             sqr;
    logic             sqrt_start;
    logic             store;
    logic             commit_hold;
    logic             commit_full;
    logic [SEL_W-1:0] sel;
  } cmd_t;

  typedef struct packed {
    logic zhold_hit;
    logic sqrt_done;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/core/bfsj_sqrt.sv =====
// Bit-serial integer square root, one root bit per cycle.
module bfsj_sqrt
  import bfsj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RAD_W-1:0] rad,
  output logic             done,
  output logic [MAG_W-1:0] root
);

  logic [RAD_W-1:0] rad_r, rad_nxt;
  logic [MAG_W+2:0] rem_r, rem_nxt;
  logic [MAG_W-1:0] root_r, root_nxt;
  logic [4:0]       cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [MAG_W+2:0] rem_sh, trial;

  always_comb begin
    rem_sh   = {rem_r[MAG_W:0], rad_r[RAD_W-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = rad;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = 5'(MAG_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[RAD_W-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[MAG_W-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[MAG_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    cnt_r  <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

// ===== rtl/core/bfsj_ctrl.sv =====
// Judge sequencer: seven magnitudes and final decision, or the zero-sequence hold.
module bfsj_ctrl
  import bfsj_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_CHECK = 9'b000000010,
    S_COMP  = 9'b000000100,
    S_RND   = 9'b000001000,
    S_SQR   = 9'b000010000,
    S_ADD   = 9'b000100000,
    S_ROOT  = 9'b001000000,
    S_FINAL = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t           st_r, st_nxt;
  logic [SEL_W-1:0] sel_r, sel_nxt;

  always_comb begin
    st_nxt  = st_r;
    sel_nxt = sel_r;
    cmd     = '0;
    cmd.sel = sel_r;
    case (st_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load = 1'b1;
          st_nxt   = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.zhold_hit) begin
          if (sts.out_free) begin
            cmd.commit_hold = 1'b1;
            st_nxt          = S_IDLE;
          end
        end else begin
          sel_nxt = SEL_A;
          st_nxt  = S_COMP;
        end
      end
      S_COMP: begin
        cmd.comp = 1'b1;
        st_nxt   = S_RND;
      end
      S_RND: begin
        cmd.rnd = 1'b1;
        st_nxt  = S_SQR;
      end
      S_SQR: begin
        cmd.sqr = 1'b1;
        st_nxt  = S_ADD;
      end
      S_ADD: begin
        cmd.sqrt_start = 1'b1;
        st_nxt         = S_ROOT;
      end
      S_ROOT: begin
        if (sts.sqrt_done) begin
          cmd.store = 1'b1;
          if (sel_r == SEL_MI2) begin
            st_nxt = S_FINAL;
          end else begin
            sel_nxt = sel_r + 3'd1;
            st_nxt  = S_COMP;
          end
        end
      end
      S_FINAL: begin
        if (sts.out_free) begin
          cmd.commit_full = 1'b1;
          st_nxt          = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= S_IDLE;
      sel_r <= SEL_A;
    end else begin
      st_r  <= st_nxt;
      sel_r <= sel_nxt;
    end
  end

  assign in_tready = (st_r == S_IDLE);

  // The root unit only finishes while the sequencer waits for it.
  a_done_in_root: assert property (@(posedge clk) disable iff (!rst_n)
    sts.sqrt_done |-> st_r == S_ROOT)
    else $error("root finished outside the wait state");

endmodule

// ===== rtl/core/bfsj_dp.sv =====
// Datapath: item and config registers, magnitude chain, criteria and result register.
module bfsj_dp
  import bfsj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [LVL_W-1:0] cfg_wdata,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  function automatic logic signed [XW-1:0] sx(input logic signed [CW-1:0] v);
    sx = {{(XW-CW){v[CW-1]}}, v};
  endfunction

  function automatic logic signed [XW-1:0] round17(input logic signed [XW-1:0] v);
    logic signed [XW-1:0] m;
    m = -v;
    if (!v[XW-1]) round17 = (v + XW'(65536)) >>> 17;
    else          round17 = -((m + XW'(65536)) >>> 17);
  endfunction

  logic [IN_W-1:0]  item_r;
  logic [LVL_W-1:0] pol_r, zcl_r, mll_r, spl_r, isl_r;
  logic [HOLD_W-1:0] hold_r;
  logic [TW-1:0]    zh_start_r, ih_start_r, sum_r;
  logic             zh_valid_r, ih_valid_r;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;

  logic signed [XW-1:0] x_r, y_r;
  logic                 neg_r;
  logic signed [RW-1:0] rx_r, ry_r;
  logic [RAD_W-1:0]     sqx_r, sqy_r;
  logic [MAG_W-1:0]     mag_r [N_MAG];
  logic                 sqrt_done;
  logic [MAG_W-1:0]     root;

  // Field views of the held item.
  logic [47:0]       f_cur [3];
  logic [47:0]       f_mem [3];
  logic [LVL_W-1:0]  f_mem0;
  logic [TW-1:0]     f_now;
  logic signed [CW-1:0] f_inst, f_old;

  assign f_cur[0] = item_r[47:0];
  assign f_cur[1] = item_r[95:48];
  assign f_cur[2] = item_r[143:96];
  assign f_mem[0] = item_r[191:144];
  assign f_mem[1] = item_r[239:192];
  assign f_mem[2] = item_r[287:240];
  assign f_mem0   = item_r[310:288];
  assign f_now    = item_r[342:311];
  assign f_inst   = item_r[366:343];
  assign f_old    = item_r[390:367];

  logic [TW-1:0] zh_elapsed, ih_elapsed;
  assign zh_elapsed = f_now - zh_start_r;
  assign ih_elapsed = f_now - ih_start_r;

  // Component selection for the slot being computed.
  logic [47:0]          set_p [3];
  logic signed [CW-1:0] re0, re1, re2, im0, im1, im2;
  logic signed [XW-1:0] n_re, n_im;
  logic signed [RW-1:0] d_im, d_re;
  logic signed [43:0]   p_im, p_re;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic                 use_mem;

  always_comb begin
    use_mem = (cmd.sel == SEL_MI0) || (cmd.sel == SEL_MI2);
    for (int k = 0; k < 3; k++) set_p[k] = use_mem ? f_mem[k] : f_cur[k];
    re0 = set_p[0][47:24]; im0 = set_p[0][23:0];
    re1 = set_p[1][47:24]; im1 = set_p[1][23:0];
    re2 = set_p[2][47:24]; im2 = set_p[2][23:0];
    if (cmd.sel == SEL_B) begin
      re0 = f_cur[1][47:24]; im0 = f_cur[1][23:0];
    end else if (cmd.sel == SEL_C) begin
      re0 = f_cur[2][47:24]; im0 = f_cur[2][23:0];
    end
    n_re = (sx(re0) <<< 1) - sx(re1) - sx(re2);
    n_im = (sx(im0) <<< 1) - sx(im1) - sx(im2);
    d_im = RW'(sx(im1) - sx(im2));
    d_re = RW'(sx(re2) - sx(re1));
    p_im = SQRT3_Q16 * d_im;
    p_re = SQRT3_Q16 * d_re;
    case (cmd.sel)
      SEL_I0, SEL_MI0: begin
        x_nxt = sx(re0) + sx(re1) + sx(re2);
        y_nxt = sx(im0) + sx(im1) + sx(im2);
      end
      SEL_I2, SEL_MI2: begin
        x_nxt = (n_re <<< 16) + {{(XW-44){p_im[43]}}, p_im};
        y_nxt = (n_im <<< 16) + {{(XW-44){p_re[43]}}, p_re};
      end
      default: begin
        x_nxt = sx(re0);
        y_nxt = sx(im0);
      end
    endcase
  end

  logic signed [XW-1:0] tx, ty, cx, cy;
  always_comb begin
    tx = neg_r ? round17(x_r) : x_r;
    ty = neg_r ? round17(y_r) : y_r;
    cx = (tx > MAG_CAP) ? MAG_CAP : ((tx < -MAG_CAP) ? -MAG_CAP : tx);
    cy = (ty > MAG_CAP) ? MAG_CAP : ((ty < -MAG_CAP) ? -MAG_CAP : ty);
  end

  logic signed [2*RW-1:0] sq_x, sq_y;
  assign sq_x = rx_r * rx_r;
  assign sq_y = ry_r * ry_r;

  bfsj_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.sqrt_start),
    .rad   (sqx_r + sqy_r),
    .done  (sqrt_done),
    .root  (root)
  );

  // Final criteria.
  logic [MAG_W-1:0] mem0_x, zdiff;
  logic             po, zc, zr, nr, ihit, inst_f;
  logic signed [CW:0] sdiff;
  logic [CW:0]      dabs;
  logic [TW:0]      sum_w;
  logic [TW-1:0]    sum_sat;

  always_comb begin
    mem0_x = {2'b00, f_mem0};
    zdiff  = (mag_r[SEL_I0] > mem0_x) ? (mag_r[SEL_I0] - mem0_x) : (mem0_x - mag_r[SEL_I0]);
    po = (mag_r[SEL_A] > {2'b00, pol_r}) || (mag_r[SEL_B] > {2'b00, pol_r}) ||
         (mag_r[SEL_C] > {2'b00, pol_r});
    zc = zdiff > {2'b00, zcl_r};
    zr = (mag_r[SEL_MI0] < {2'b00, mll_r}) && (mag_r[SEL_I0] > {2'b00, spl_r});
    nr = (mag_r[SEL_MI2] < {2'b00, mll_r}) && (mag_r[SEL_I2] > {2'b00, spl_r});
    ihit  = ih_valid_r && (ih_elapsed < {{(TW-HOLD_W){1'b0}}, hold_r});
    sdiff = {f_inst[CW-1], f_inst} - {f_old[CW-1], f_old};
    dabs  = sdiff[CW] ? (CW+1)'(-sdiff) : (CW+1)'(sdiff);
    sum_w = {1'b0, sum_r} + {{(TW-CW){1'b0}}, dabs};
    sum_sat = sum_w[TW] ? {TW{1'b1}} : sum_w[TW-1:0];
    inst_f  = ihit || (sum_sat > {{(TW-LVL_W){1'b0}}, isl_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_tdata;
    if (cmd.comp) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      neg_r <= (cmd.sel == SEL_I2) || (cmd.sel == SEL_MI2);
    end
    if (cmd.rnd) begin
      rx_r <= cx[RW-1:0];
      ry_r <= cy[RW-1:0];
    end
    if (cmd.sqr) begin
      sqx_r <= sq_x[RAD_W-1:0];
      sqy_r <= sq_y[RAD_W-1:0];
    end
    if (cmd.store) mag_r[cmd.sel] <= root;
    if (cmd.commit_hold) out_data_r <= HOLD_WORD;
    if (cmd.commit_full)
      out_data_r <= {1'b0, inst_f, nr, zr, zc, po, 1'b0, po | zc | zr | nr | inst_f};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r       <= 23'd72090;
      zcl_r       <= 23'd1966;
      mll_r       <= 23'd5243;
      spl_r       <= 23'd6554;
      isl_r       <= 23'd13107;
      hold_r      <= 8'd5;
      zh_start_r  <= '0;
      zh_valid_r  <= 1'b0;
      ih_start_r  <= '0;
      ih_valid_r  <= 1'b0;
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PHASE_OVER: pol_r  <= cfg_wdata;
          REG_ZERO_CHG:   zcl_r  <= cfg_wdata;
          REG_MEM_LOW:    mll_r  <= cfg_wdata;
          REG_SEQ_PICKUP: spl_r  <= cfg_wdata;
          REG_INST_SUM:   isl_r  <= cfg_wdata;
          REG_HOLD_TICKS: hold_r <= cfg_wdata[HOLD_W-1:0];
          default: ;
        endcase
      end
      if (cmd.commit_full) begin
        zh_valid_r <= zc;
        if (zc) zh_start_r <= f_now;
        if (!ihit) begin
          if (inst_f) begin
            sum_r      <= '0;
            ih_start_r <= f_now;
            ih_valid_r <= 1'b1;
          end else begin
            sum_r      <= sum_sat;
            ih_valid_r <= 1'b0;
          end
        end
      end
      if (cmd.commit_hold || cmd.commit_full) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign sts.zhold_hit = zh_valid_r && (zh_elapsed <= {{(TW-HOLD_W){1'b0}}, hold_r});
  assign sts.sqrt_done = sqrt_done;
  assign sts.out_free  = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit_hold || cmd.commit_full) |-> sts.out_free)
    else $error("result written over a word not yet taken");

  a_hold_word: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_hold |=> out_valid_r && (out_data_r == HOLD_WORD))
    else $error("zero-sequence hold word malformed");

  a_hold_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_hold |=> $stable(sum_r) && $stable(zh_start_r) && $stable(ih_valid_r))
    else $error("state changed during zero-sequence hold");

endmodule

// ===== rtl/core/breaker_failure_start_judge_unit.sv =====
// Top level of the breaker failure start judge.
// A word is loaded and checked against the zero-sequence hold; outside it the seven
// magnitudes and the final decision follow, and no new word is taken until its result
// is committed. One shared square-root unit gives a root bit per cycle for all seven.
// Reset (synchronous, rst_n low): thresholds take their defaults, both holds are
// invalid, the change sum is zero; no clearing pass is needed.
module breaker_failure_start_judge_unit
  import bfsj_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // cur_a, cur_b, cur_c, mem_a, mem_b, mem_c, mem_zero_seq, now_tick,
  // inst_sample, old_sample, one zero pad bit
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // start_res, in_zero_hold, phase_over, zero_change, zero_rise, neg_rise,
  // inst_change, one zero pad bit
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_addr,
  input  logic [LVL_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  bfsj_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfsj_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sim/breaker_failure_start_judge_unit_tb.sv =====
// Self-checking testbench for the breaker failure start judge: random and directed sample words.
module breaker_failure_start_judge_unit_tb
  import bfsj_pkg::*;
();

  // One input word, highest field first so that the cast gives the port layout.
  typedef struct packed {
    logic        pad;
    logic [23:0] old_s;
    logic [23:0] inst_s;
    logic [31:0] tick;
    logic [22:0] mem0;
    logic [47:0] mem_c;
    logic [47:0] mem_b;
    logic [47:0] mem_a;
    logic [47:0] cur_c;
    logic [47:0] cur_b;
    logic [47:0] cur_a;
  } sample_t;

  typedef struct packed {
    logic pad;
    logic inst_change;
    logic neg_rise;
    logic zero_rise;
    logic zero_change;
    logic phase_over;
    logic in_zero_hold;
    logic start_res;
  } verdict_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;
  logic             out_tvalid;
  logic             out_tready;
  logic [OUT_W-1:0] out_tdata;
  logic             cfg_we;
  logic [2:0]       cfg_addr;
  logic [LVL_W-1:0] cfg_wdata;

  breaker_failure_start_judge_unit DUT (.*);

  sample_t  pending_words[$];
  verdict_t expected_verdicts[$];
  sample_t  offered;
  int       errors = 0;
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       stall_req = 0;
  int       stall_seen = 0;
  int       stall_left = 0;
  longint   cycles = 0;

  // Shadow of the thresholds and of the judge state.
  logic [22:0] lvl_phase, lvl_zchg, lvl_memlow, lvl_pickup, lvl_inst;
  logic [7:0]  hold_len;
  logic [31:0] zhold_at, ihold_at, delta_sum;
  logic        zhold_on, ihold_on;
  logic [31:0] tick_now;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint cap(longint v);
    if (v > 64'sd16777216) return 64'sd16777216;
    if (v < -64'sd16777216) return -64'sd16777216;
    return v;
  endfunction

  function automatic longint unsigned mag(longint re, longint im);
    longint r, i;
    r = cap(re);
    i = cap(im);
    return int_root(longint'(r * r + i * i));
  endfunction

  // Divide by 2^17 with halves rounded away from zero.
  function automatic longint round17(longint x);
    if (x >= 0) return (x + 65536) / 131072;
    return -((-x + 65536) / 131072);
  endfunction

  function automatic longint unsigned zero_seq(logic [47:0] a, logic [47:0] b, logic [47:0] c);
    return mag(sx24(a[47:24]) + sx24(b[47:24]) + sx24(c[47:24]),
               sx24(a[23:0]) + sx24(b[23:0]) + sx24(c[23:0]));
  endfunction

  function automatic longint unsigned neg_seq(logic [47:0] a, logic [47:0] b, logic [47:0] c);
    longint x, y;
    x = (2 * sx24(a[47:24]) - sx24(b[47:24]) - sx24(c[47:24])) * 65536
        + 64'sd113512 * (sx24(b[23:0]) - sx24(c[23:0]));
    y = (2 * sx24(a[23:0]) - sx24(b[23:0]) - sx24(c[23:0])) * 65536
        + 64'sd113512 * (sx24(c[47:24]) - sx24(b[47:24]));
    return mag(round17(x), round17(y));
  endfunction

  task automatic judge_sample(sample_t s);
    verdict_t v;
    longint unsigned i0, i2, mi0, mi2, d0, sum;
    longint ds;
    v = '0;
    if (zhold_on && (s.tick - zhold_at) <= {24'd0, hold_len}) begin
      v.start_res = 1;
      v.in_zero_hold = 1;
    end else begin
      zhold_on = 0;
      i0  = zero_seq(s.cur_a, s.cur_b, s.cur_c);
      i2  = neg_seq(s.cur_a, s.cur_b, s.cur_c);
      mi0 = zero_seq(s.mem_a, s.mem_b, s.mem_c);
      mi2 = neg_seq(s.mem_a, s.mem_b, s.mem_c);
      v.phase_over = mag(sx24(s.cur_a[47:24]), sx24(s.cur_a[23:0])) > lvl_phase ||
                     mag(sx24(s.cur_b[47:24]), sx24(s.cur_b[23:0])) > lvl_phase ||
                     mag(sx24(s.cur_c[47:24]), sx24(s.cur_c[23:0])) > lvl_phase;
      d0 = (i0 > s.mem0) ? i0 - s.mem0 : s.mem0 - i0;
      if (d0 > lvl_zchg) begin
        v.zero_change = 1;
        zhold_at = s.tick;
        zhold_on = 1;
      end
      v.zero_rise = mi0 < lvl_memlow && i0 > lvl_pickup;
      v.neg_rise  = mi2 < lvl_memlow && i2 > lvl_pickup;
      if (ihold_on && (s.tick - ihold_at) < {24'd0, hold_len}) begin
        v.inst_change = 1;
      end else begin
        ihold_on = 0;
        ds = sx24(s.inst_s) - sx24(s.old_s);
        if (ds < 0) ds = -ds;
        sum = longint'(delta_sum) + ds;
        delta_sum = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
        if (delta_sum > lvl_inst) begin
          delta_sum = 0;
          ihold_at = s.tick;
          ihold_on = 1;
          v.inst_change = 1;
        end
      end
      v.start_res = v.phase_over | v.zero_change | v.zero_rise | v.neg_rise | v.inst_change;
    end
    expected_verdicts.push_back(v);
  endtask

  // Sender.
  always @(posedge clk) begin
    logic nv;
    if (!rst_n) begin
      in_tvalid <= 0;
      in_tdata <= '0;
    end else begin
      nv = in_tvalid;
      if (in_tvalid && in_tready) begin
        judge_sample(offered);
        nv = 0;
      end
      if (!nv && pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        offered = pending_words.pop_front();
        in_tdata <= offered;
        nv = 1;
      end
      in_tvalid <= nv;
    end
  end

  // Receiver and checker.
  always @(posedge clk) begin
    verdict_t got, want;
    if (!rst_n) begin
      out_tready <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_verdicts.size() == 0) begin
          $error("result word %h with nothing expected", got);
          errors++;
        end else begin
          want = expected_verdicts.pop_front();
          if (got.start_res !== want.start_res) begin
            $error("start_res exp %0b got %0b", want.start_res, got.start_res); errors++;
          end
          if (got.in_zero_hold !== want.in_zero_hold) begin
            $error("in_zero_hold exp %0b got %0b", want.in_zero_hold, got.in_zero_hold); errors++;
          end
          if (got.phase_over !== want.phase_over) begin
            $error("phase_over exp %0b got %0b", want.phase_over, got.phase_over); errors++;
          end
          if (got.zero_change !== want.zero_change) begin
            $error("zero_change exp %0b got %0b", want.zero_change, got.zero_change); errors++;
          end
          if (got.zero_rise !== want.zero_rise) begin
            $error("zero_rise exp %0b got %0b", want.zero_rise, got.zero_rise); errors++;
          end
          if (got.neg_rise !== want.neg_rise) begin
            $error("neg_rise exp %0b got %0b", want.neg_rise, got.neg_rise); errors++;
          end
          if (got.inst_change !== want.inst_change) begin
            $error("inst_change exp %0b got %0b", want.inst_change, got.inst_change); errors++;
          end
        end
      end
      if (stall_req != stall_seen) begin
        stall_seen = stall_req;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 0;
      end else begin
        out_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  function automatic logic [47:0] phasor(int kind);
    logic [23:0] re, im;
    case (kind)
      0: begin
        re = 24'($signed($urandom_range(0, 6000)) - 3000);
        im = 24'($signed($urandom_range(0, 6000)) - 3000);
      end
      1: begin
        re = 24'($signed($urandom_range(0, 200000)) - 100000);
        im = 24'($signed($urandom_range(0, 200000)) - 100000);
      end
      default: begin
        re = 24'($urandom);
        im = 24'($urandom);
      end
    endcase
    return {re, im};
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int k, m, dmax;
    logic [23:0] base;
    k = $urandom_range(0, 9);
    k = (k < 5) ? 0 : (k < 9) ? 1 : 2;
    m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : 0;
    s.cur_a = phasor(k);
    s.cur_b = phasor($urandom_range(0, 3) == 0 ? 2 : k);
    s.cur_c = phasor(k);
    s.mem_a = phasor(m);
    s.mem_b = phasor(m);
    s.mem_c = phasor(m);
    s.mem0 = ($urandom_range(0, 7) == 0) ? 23'($urandom) : 23'($urandom_range(0, 12000));
    if ($urandom_range(0, 49) == 0) tick_now = $urandom;
    else tick_now = tick_now + $urandom_range(0, 3);
    s.tick = tick_now;
    base = 24'($urandom);
    dmax = ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 6000;
    s.inst_s = base;
    s.old_s = base + 24'($urandom_range(0, dmax));
    s.pad = 0;
    return s;
  endfunction

  function automatic sample_t quiet_sample(logic [31:0] t);
    sample_t s;
    s = '0;
    s.tick = t;
    return s;
  endfunction

  task automatic wait_drained();
    while (pending_words.size() > 0 || in_tvalid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_levels(logic [22:0] p, logic [22:0] z, logic [22:0] ml,
                            logic [22:0] sp, logic [22:0] il, logic [7:0] h);
    logic [22:0] vals[6];
    logic [2:0]  idx[6];
    vals = '{p, z, ml, sp, il, 23'(h)};
    idx = '{REG_PHASE_OVER, REG_ZERO_CHG, REG_MEM_LOW, REG_SEQ_PICKUP, REG_INST_SUM,
            REG_HOLD_TICKS};
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1;
      cfg_addr <= idx[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 0;
    lvl_phase = p; lvl_zchg = z; lvl_memlow = ml; lvl_pickup = sp; lvl_inst = il;
    hold_len = h;
  endtask

  initial begin
    sample_t s;
    rst_n = 0;
    cfg_we = 0;
    cfg_addr = '0;
    cfg_wdata = '0;
    lvl_phase = 72090; lvl_zchg = 1966; lvl_memlow = 5243; lvl_pickup = 6554;
    lvl_inst = 13107; hold_len = 5;
    zhold_on = 0; ihold_on = 0; zhold_at = 0; ihold_at = 0; delta_sum = 0;
    tick_now = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed part under the default thresholds.
    send_idle_pct = 25; recv_idle_pct = 80;
    pending_words.push_back(quiet_sample(0));
    s = '0;
    s.cur_a = {24'h7FFFFF, 24'h800000};
    s.cur_b = {24'h800000, 24'h800000};
    s.cur_c = {24'h7FFFFF, 24'h7FFFFF};
    s.mem_a = s.cur_a; s.mem_b = s.cur_b; s.mem_c = s.cur_c;
    s.mem0 = 23'h7FFFFF;
    s.tick = 32'hFFFF_FFFE;
    s.inst_s = 24'h7FFFFF; s.old_s = 24'h800000;
    pending_words.push_back(s);
    // The zero-sequence hold started at the top of the time range wraps around.
    pending_words.push_back(quiet_sample(32'd3));
    pending_words.push_back(quiet_sample(32'd4));
    // Phase overcurrent alone: a balanced set, so no sequence component appears.
    s = quiet_sample(100);
    s.cur_a = {24'd80000, 24'd0};
    s.cur_b = {-24'sd40000, -24'sd69282};
    s.cur_c = {-24'sd40000, 24'sd69282};
    s.mem0 = 23'd0;
    pending_words.push_back(s);
    // Zero-sequence change at tick 200, then the hold edge at exactly hold_ticks.
    s = quiet_sample(200);
    s.cur_a = {24'd10000, 24'd0};
    pending_words.push_back(s);
    for (int t = 201; t <= 206; t++) pending_words.push_back(quiet_sample(t));
    s = quiet_sample(0);
    s.cur_a = {24'd10000, 24'd0};
    s.mem0 = 23'd10000;
    pending_words.push_back(s);
    // Negative sequence rise from a quiet memory.
    s = quiet_sample(300);
    s.cur_a = {24'd8000, 24'd0};
    s.cur_b = {-24'sd4000, 24'sd6928};
    s.cur_c = {-24'sd4000, -24'sd6928};
    pending_words.push_back(s);
    // Instantaneous sum builds up, then holds, then the hold ends at hold_ticks.
    for (int t = 400; t < 410; t++) begin
      s = quiet_sample(t);
      s.inst_s = 24'd5000;
      s.old_s = 24'd0;
      pending_words.push_back(s);
    end
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 25; recv_idle_pct = 80; end
        1: begin send_idle_pct = 80; recv_idle_pct = 25; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      case (ph)
        0: set_levels(72090, 1966, 5243, 6554, 13107, 5);
        1: set_levels(0, 0, 0, 0, 0, 0);
        2: set_levels(23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 23'h7FFFFF, 8'hFF);
        3: set_levels(100000, 3000, 0, 8000, 20000, 1);
        default: set_levels(23'($urandom_range(1000, 150000)), 23'($urandom_range(0, 8000)),
                            23'($urandom_range(0, 8000)), 23'($urandom_range(0, 12000)),
                            23'($urandom_range(0, 30000)), 8'($urandom_range(0, 12)));
      endcase
      if (ph == 2) stall_req++;
      for (int n = 0; n < 240; n++) pending_words.push_back(random_sample());
      // The stimulus waits here until every result of the phase is in.
      wait_drained();
    end

    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bfsj_pkg.sv
rtl/core/bfsj_sqrt.sv
rtl/core/bfsj_ctrl.sv
rtl/core/bfsj_dp.sv
rtl/core/breaker_failure_start_judge_unit.sv
sim/breaker_failure_start_judge_unit_tb.sv
